[sv/rrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrc_pkg;

  // geometry and channel widths
  localparam int REGIONS        = 4;
  localparam int COORD_BITS     = 12;
  localparam int REG_SLOTS      = 4;
  localparam int REGION_BITS    = 48;
  localparam int FIELD_SPAN     = 4 * COORD_BITS;
  localparam int WIDE_BITS      = (FIELD_SPAN > REGION_BITS) ? FIELD_SPAN : REGION_BITS;
  localparam int COUNT_BITS     = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CHAN_BITS      = 8;
  localparam int SUM_BITS       = CHAN_BITS + 2;
  localparam int DIVIDEND_BITS  = 2 * CHAN_BITS;

  // divider split: quotient bits produced per pipeline stage
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = CHAN_BITS / BITS_PER_STAGE;
  localparam int PIPE_STAGES    = DIV_STAGES + 2;

  localparam logic [CHAN_BITS:0] CHAN_FULL = {1'b0, {CHAN_BITS{1'b1}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_REGION_COUNT = 3'd0,
    CFG_REGION_ZERO  = 3'd1,
    CFG_REGION_ONE   = 3'd2,
    CFG_REGION_TWO   = 3'd3,
    CFG_REGION_THREE = 3'd4
  } cfg_idx_e;

  typedef logic [REG_SLOTS-1:0][REGION_BITS-1:0] region_set_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [CHAN_BITS-1:0]  red_in;
    logic [CHAN_BITS-1:0]  green_in;
    logic [CHAN_BITS-1:0]  blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red_out;
    logic [CHAN_BITS-1:0] green_out;
    logic [CHAN_BITS-1:0] blue_out;
    logic                 inside_region;
  } pix_out_t;

  // state of one pixel while both divisions run
  typedef struct packed {
    logic                 in_region;
    logic [SUM_BITS-1:0]  divisor;
    logic [SUM_BITS-1:0]  rem_r;
    logic [SUM_BITS-1:0]  rem_g;
    logic [CHAN_BITS-1:0] low_r;
    logic [CHAN_BITS-1:0] low_g;
    logic [CHAN_BITS-1:0] quo_r;
    logic [CHAN_BITS-1:0] quo_g;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } div_t;

endpackage

`default_nettype wire

[sv/rrc_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrc_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic [rrc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [rrc_pkg::REGION_BITS-1:0]   cfg_data_i,
  output logic [rrc_pkg::COUNT_BITS-1:0]         count_o,
  output rrc_pkg::region_set_t                   regions_o
);
  import rrc_pkg::*;

  logic [COUNT_BITS-1:0] count_d, count_q;
  region_set_t           regions_d, regions_q;

  always_comb begin
    count_d   = count_q;
    regions_d = regions_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_REGION_COUNT: count_d      = cfg_data_i[COUNT_BITS-1:0];
        CFG_REGION_ZERO:  regions_d[0] = cfg_data_i;
        CFG_REGION_ONE:   regions_d[1] = cfg_data_i;
        CFG_REGION_TWO:   regions_d[2] = cfg_data_i;
        CFG_REGION_THREE: regions_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      regions_q <= '0;
    end else begin
      count_q   <= count_d;
      regions_q <= regions_d;
    end
  end

  assign count_o   = count_q;
  assign regions_o = regions_q;

endmodule

`default_nettype wire

[sv/rrc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrc_front (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire rrc_pkg::pix_in_t              data_i,
  input  wire logic [rrc_pkg::COUNT_BITS-1:0] count_i,
  input  wire rrc_pkg::region_set_t          regions_i,
  output rrc_pkg::div_t                      data_o
);
  import rrc_pkg::*;

  logic [COUNT_BITS-1:0]    used;
  logic [REG_SLOTS-1:0]     hit;
  logic [SUM_BITS-1:0]      sum;
  logic [DIVIDEND_BITS-1:0] num_r, num_g;
  div_t                     div_d, div_q;

  // saturate the count at the number of implemented rectangles
  assign used = (count_i > COUNT_BITS'(REGIONS)) ? COUNT_BITS'(REGIONS) : count_i;

  for (genvar k = 0; k < REG_SLOTS; k++) begin : g_region
    logic [WIDE_BITS-1:0]  wide;
    logic [COORD_BITS-1:0] left, top, right, bottom;
    assign wide   = WIDE_BITS'(regions_i[k]);
    assign left   = wide[0*COORD_BITS +: COORD_BITS];
    assign top    = wide[1*COORD_BITS +: COORD_BITS];
    assign right  = wide[2*COORD_BITS +: COORD_BITS];
    assign bottom = wide[3*COORD_BITS +: COORD_BITS];
    // half-open box, empty when right <= left or bottom <= top
    assign hit[k] = (COUNT_BITS'(k) < used)
                    && (data_i.pixel_x >= left) && (data_i.pixel_x < right)
                    && (data_i.pixel_y >= top)  && (data_i.pixel_y < bottom);
  end

  assign sum   = SUM_BITS'(data_i.red_in) + SUM_BITS'(data_i.green_in)
               + SUM_BITS'(data_i.blue_in);
  // part * 255 as (part << 8) - part
  assign num_r = {data_i.red_in, CHAN_BITS'(0)} - DIVIDEND_BITS'(data_i.red_in);
  assign num_g = {data_i.green_in, CHAN_BITS'(0)} - DIVIDEND_BITS'(data_i.green_in);

  always_comb begin
    div_d.in_region = |hit;
    // black pixel: dividends are zero, divisor of one keeps quotients zero
    div_d.divisor = (sum == '0) ? SUM_BITS'(1) : sum;
    div_d.rem_r   = SUM_BITS'(num_r[DIVIDEND_BITS-1 -: CHAN_BITS]);
    div_d.rem_g   = SUM_BITS'(num_g[DIVIDEND_BITS-1 -: CHAN_BITS]);
    div_d.low_r   = num_r[CHAN_BITS-1:0];
    div_d.low_g   = num_g[CHAN_BITS-1:0];
    div_d.quo_r   = '0;
    div_d.quo_g   = '0;
    div_d.red     = data_i.red_in;
    div_d.green   = data_i.green_in;
    div_d.blue    = data_i.blue_in;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign data_o = div_q;

endmodule

`default_nettype wire

[sv/rrc_div_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrc_div_stage (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire rrc_pkg::div_t data_i,
  output rrc_pkg::div_t      data_o
);
  import rrc_pkg::*;

  div_t                div_d, div_q;
  logic [SUM_BITS:0]   step_r, step_g;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [SUM_BITS:0] div_bit(
    input logic [SUM_BITS-1:0] rem,
    input logic                next_bit,
    input logic [SUM_BITS-1:0] divisor
  );
    logic [SUM_BITS:0] trial;
    logic [SUM_BITS:0] wide_div;
    trial    = {rem, next_bit};
    wide_div = {1'b0, divisor};
    if (trial >= wide_div) begin
      div_bit = {1'b1, SUM_BITS'(trial - wide_div)};
    end else begin
      div_bit = {1'b0, trial[SUM_BITS-1:0]};
    end
  endfunction

  always_comb begin
    div_d  = data_i;
    step_r = '0;
    step_g = '0;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      step_r      = div_bit(div_d.rem_r, div_d.low_r[CHAN_BITS-1], div_d.divisor);
      step_g      = div_bit(div_d.rem_g, div_d.low_g[CHAN_BITS-1], div_d.divisor);
      div_d.rem_r = step_r[SUM_BITS-1:0];
      div_d.rem_g = step_g[SUM_BITS-1:0];
      div_d.low_r = {div_d.low_r[CHAN_BITS-2:0], 1'b0};
      div_d.low_g = {div_d.low_g[CHAN_BITS-2:0], 1'b0};
      div_d.quo_r = {div_d.quo_r[CHAN_BITS-2:0], step_r[SUM_BITS]};
      div_d.quo_g = {div_d.quo_g[CHAN_BITS-2:0], step_g[SUM_BITS]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign data_o = div_q;

endmodule

`default_nettype wire

[sv/rrc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rrc_back (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire rrc_pkg::div_t data_i,
  output rrc_pkg::pix_out_t  data_o
);
  import rrc_pkg::*;

  logic [CHAN_BITS:0] rg_sum, blue_dist;
  pix_out_t           out_d, out_q;

  assign rg_sum    = (CHAN_BITS+1)'(data_i.quo_r) + (CHAN_BITS+1)'(data_i.quo_g);
  assign blue_dist = (rg_sum >= CHAN_FULL) ? (rg_sum - CHAN_FULL) : (CHAN_FULL - rg_sum);

  always_comb begin
    if (data_i.in_region) begin
      out_d.red_out       = data_i.quo_r;
      out_d.green_out     = data_i.quo_g;
      out_d.blue_out      = blue_dist[CHAN_BITS-1:0];
      out_d.inside_region = 1'b1;
    end else begin
      out_d.red_out       = data_i.red;
      out_d.green_out     = data_i.green;
      out_d.blue_out      = data_i.blue;
      out_d.inside_region = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign data_o = out_q;

endmodule

`default_nettype wire

[sv/roi_rg_chromaticity.sv]
// rg chromaticity inside up to four rectangles of interest. each pixel transfer
// carries a column, a row and 8-bit red, green and blue; a pixel inside any
// enabled half-open rectangle comes out as r = floor(R*255/S),
// g = floor(G*255/S), b = |r+g-255| with S = R+G+B, flagged by inside_region,
// and any other pixel passes through unchanged. the block takes one pixel per
// clock while the output is not stalled, and each result passes through six
// register stages: one stage for the region test, component sum and dividends,
// four stages of a pipelined restoring divider (two quotient bits per stage,
// red and green side by side), and one output register. stages keep their own
// valid bits, so a stall on the output fills bubbles first and loses nothing.
// configuration writes (region_count at index 0, the four packed rectangles at
// indices 1 to 4, other indices ignored) are always accepted and belong between
// bursts, when no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

module roi_rg_chromaticity (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rrc_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [rrc_pkg::REGION_BITS-1:0]   cfg_data_i,
  // pixel input
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire rrc_pkg::pix_in_t                  in_data_i,
  // pixel output
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output rrc_pkg::pix_out_t                      out_data_o
);
  import rrc_pkg::*;

  localparam int LAST = PIPE_STAGES - 1;

  logic [COUNT_BITS-1:0]  region_count;
  region_set_t            regions;

  // per-stage valid and load enable; stage 0 is the front, LAST the output
  logic [PIPE_STAGES-1:0] vld_d, vld_q;
  logic [PIPE_STAGES-1:0] en;
  logic [PIPE_STAGES-1:0] vld_prev;

  div_t                   div_bus [DIV_STAGES+1];

  // register file never stalls a transfer
  assign cfg_ready_o = 1'b1;

  rrc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .count_o     (region_count),
    .regions_o   (regions)
  );

  // a stage may load when it is empty or its content moves on this cycle
  always_comb begin
    en[LAST] = ~vld_q[LAST] | out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign vld_prev = {vld_q[LAST-1:0], in_valid_i};

  always_comb begin
    for (int k = 0; k < PIPE_STAGES; k++) begin
      vld_d[k] = en[k] ? vld_prev[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[LAST];

  // region test, sum and dividends
  rrc_front u_front (
    .clk_i     (clk_i),
    .en_i      (en[0]),
    .data_i    (in_data_i),
    .count_i   (region_count),
    .regions_i (regions),
    .data_o    (div_bus[0])
  );

  // divider pipeline, most significant quotient bits first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rrc_div_stage u_stage (
      .clk_i  (clk_i),
      .en_i   (en[s+1]),
      .data_i (div_bus[s]),
      .data_o (div_bus[s+1])
    );
  end

  // blue from r and g, pass-through select, output register
  rrc_back u_back (
    .clk_i  (clk_i),
    .en_i   (en[LAST]),
    .data_i (div_bus[DIV_STAGES]),
    .data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // input stalls only when every stage is full and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld_q) && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // a stage that could not move keeps its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(vld_q & ~en) & ~vld_q) == '0))
    else $error("stalled pipeline stage lost its pixel");

  // normalized red and green never add up past full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.inside_region) |->
      (((CHAN_BITS+1)'(out_data_o.red_out) + (CHAN_BITS+1)'(out_data_o.green_out))
       <= CHAN_FULL))
    else $error("chromaticity sum exceeds full scale");

  // blue closes the sum to full scale inside a region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.inside_region) |->
      (((CHAN_BITS+1)'(out_data_o.red_out) + (CHAN_BITS+1)'(out_data_o.green_out)
        + (CHAN_BITS+1)'(out_data_o.blue_out)) == CHAN_FULL))
    else $error("blue does not complement red and green");
`endif

endmodule

`default_nettype wire

[bench/roi_rg_chromaticity_test.sv]
`timescale 1ns / 1ps

module roi_rg_chromaticity_test;
  import rrc_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int CHAN_MAX = (1 << CHAN_BITS) - 1;
  // cycles with no transfer on any channel before the run is abandoned
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [REGION_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_data;

  // shadow copy of the region registers, updated on each accepted write
  logic [COUNT_BITS-1:0] region_count_m = '0;
  logic [REGION_BITS-1:0] region_m[REG_SLOTS] = '{default: '0};

  // normalized pixels waiting for their output transfer, oldest first
  pix_out_t expected_pixels[$];

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int errors = 0;
  int pixels_sent = 0;
  int inside_sent = 0;
  int settings_used = 0;
  int quiet_cycles = 0;

  roi_rg_chromaticity dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // chromaticity of one pixel under the current region setting
  function automatic pix_out_t chroma_of(input pix_in_t p);
    pix_out_t res;
    int unsigned used, red, green, sum, r, g;
    logic [REGION_BITS-1:0] rect;
    logic hit;
    used = (region_count_m > REGIONS) ? REGIONS : region_count_m;
    hit = 1'b0;
    for (int k = 0; k < REG_SLOTS; k++) begin
      rect = region_m[k];
      // half-open: left and top inside, right and bottom outside
      if (k < used &&
          p.pixel_x >= rect[0 +: COORD_BITS] && p.pixel_x < rect[2*COORD_BITS +: COORD_BITS] &&
          p.pixel_y >= rect[COORD_BITS +: COORD_BITS] &&
          p.pixel_y < rect[3*COORD_BITS +: COORD_BITS]) begin
        hit = 1'b1;
      end
    end
    if (hit) begin
      red = p.red_in;
      green = p.green_in;
      sum = red + green + p.blue_in;
      // a zero component never divides, which also covers an all-black pixel
      r = (red == 0 || sum == 0) ? 0 : (red * CHAN_MAX) / sum;
      g = (green == 0 || sum == 0) ? 0 : (green * CHAN_MAX) / sum;
      res.red_out = CHAN_BITS'(r);
      res.green_out = CHAN_BITS'(g);
      res.blue_out = CHAN_BITS'((r + g >= CHAN_MAX) ? r + g - CHAN_MAX : CHAN_MAX - r - g);
      res.inside_region = 1'b1;
    end else begin
      res.red_out = p.red_in;
      res.green_out = p.green_in;
      res.blue_out = p.blue_in;
      res.inside_region = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [REGION_BITS-1:0] pack_rect(input int l, input int t,
                                                       input int r, input int b);
    return {COORD_BITS'(b), COORD_BITS'(r), COORD_BITS'(t), COORD_BITS'(l)};
  endfunction

  function automatic pix_in_t make_pixel(input int x, input int y, input int r,
                                         input int g, input int b);
    pix_in_t p;
    p.pixel_x = COORD_BITS'(x);
    p.pixel_y = COORD_BITS'(y);
    p.red_in = CHAN_BITS'(r);
    p.green_in = CHAN_BITS'(g);
    p.blue_in = CHAN_BITS'(b);
    return p;
  endfunction

  // zero and full scale show up often, the rest is uniform
  function automatic logic [CHAN_BITS-1:0] random_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return CHAN_BITS'(CHAN_MAX);
      default: return CHAN_BITS'($urandom_range(CHAN_MAX));
    endcase
  endfunction

  function automatic logic [REGION_BITS-1:0] random_rect();
    int l, t, r, b;
    l = $urandom_range(COORD_MAX);
    t = $urandom_range(COORD_MAX);
    case ($urandom_range(9))
      0: return pack_rect(0, 0, COORD_MAX, COORD_MAX);
      1: return REGION_BITS'({$urandom, $urandom});
      // zero width, or right left of left
      2: return pack_rect(l, t, l - $urandom_range(1), t + $urandom_range(50));
      default: begin
        r = l + $urandom_range(1, 600);
        b = t + $urandom_range(1, 600);
        return pack_rect(l, t, (r > COORD_MAX) ? COORD_MAX : r,
                         (b > COORD_MAX) ? COORD_MAX : b);
      end
    endcase
  endfunction

  // mostly aimed at one of the rectangles, edges included, else anywhere
  function automatic pix_in_t random_pixel();
    pix_in_t p;
    logic [REGION_BITS-1:0] rect;
    rect = region_m[$urandom_range(REG_SLOTS - 1)];
    if ($urandom_range(3) != 0) begin
      p.pixel_x = COORD_BITS'($urandom_range(rect[2*COORD_BITS +: COORD_BITS],
                                             rect[0 +: COORD_BITS]));
      p.pixel_y = COORD_BITS'($urandom_range(rect[3*COORD_BITS +: COORD_BITS],
                                             rect[COORD_BITS +: COORD_BITS]));
    end else begin
      p.pixel_x = COORD_BITS'($urandom_range(COORD_MAX));
      p.pixel_y = COORD_BITS'($urandom_range(COORD_MAX));
    end
    p.red_in = random_channel();
    p.green_in = random_channel();
    p.blue_in = random_channel();
    return p;
  endfunction

  // stop sending and wait until every pixel in flight has come out
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [REGION_BITS-1:0] value);
    drain_pixels();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    // spare indices are dropped by the block
    if (idx == CFG_REGION_COUNT) begin
      region_count_m = value[COUNT_BITS-1:0];
    end else if (idx <= CFG_REGION_THREE) begin
      region_m[idx - 1] = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one pixel transfer, after a random gap when the sender idles
  task automatic send_pixel(input pix_in_t p);
    int gap;
    pix_out_t res;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
    res = chroma_of(p);
    expected_pixels.push_back(res);
    pixels_sent++;
    if (res.inside_region) inside_sent++;
  endtask

  // no region enabled yet: everything passes through
  task automatic test_passthrough_after_reset();
    send_pixel(make_pixel(0, 0, 0, 0, 0));
    send_pixel(make_pixel(COORD_MAX, COORD_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX));
    send_pixel(make_pixel(1234, 2345, 17, 200, 99));
  endtask

  // almost the whole frame, component extremes and the excluded last row and column
  task automatic test_chroma_extremes();
    write_register(CFG_REGION_ZERO, pack_rect(0, 0, COORD_MAX, COORD_MAX));
    write_register(CFG_REGION_COUNT, REGION_BITS'(1));
    send_pixel(make_pixel(0, 0, 0, 0, 0));
    send_pixel(make_pixel(COORD_MAX - 1, COORD_MAX - 1, CHAN_MAX, CHAN_MAX, CHAN_MAX));
    send_pixel(make_pixel(1, 2, CHAN_MAX, 0, 0));
    send_pixel(make_pixel(3, 4, 0, CHAN_MAX, 0));
    send_pixel(make_pixel(5, 6, 0, 0, CHAN_MAX));
    send_pixel(make_pixel(7, 8, 1, 1, 1));
    send_pixel(make_pixel(COORD_MAX, 100, 10, 20, 30));
    send_pixel(make_pixel(100, COORD_MAX, 40, 50, 60));
  endtask

  // left and top included, right and bottom excluded
  task automatic test_rectangle_edges();
    write_register(CFG_REGION_ZERO, pack_rect(100, 200, 110, 210));
    send_pixel(make_pixel(100, 200, 90, 80, 70));
    send_pixel(make_pixel(109, 209, 90, 80, 70));
    send_pixel(make_pixel(110, 200, 90, 80, 70));
    send_pixel(make_pixel(99, 205, 90, 80, 70));
    send_pixel(make_pixel(105, 199, 90, 80, 70));
    send_pixel(make_pixel(105, 210, 90, 80, 70));
  endtask

  // empty and inverted rectangles, overlap, count saturation, spare indices
  task automatic test_region_count_and_index();
    write_register(CFG_REGION_ONE, pack_rect(300, 300, 300, 400));
    write_register(CFG_REGION_TWO, pack_rect(500, 500, 400, 600));
    write_register(CFG_REGION_THREE, pack_rect(105, 205, 120, 220));
    write_register(CFG_REGION_COUNT, REGION_BITS'(REGIONS));
    send_pixel(make_pixel(300, 350, 11, 22, 33));
    send_pixel(make_pixel(450, 550, 11, 22, 33));
    send_pixel(make_pixel(107, 207, 11, 22, 33));
    send_pixel(make_pixel(115, 215, 11, 22, 33));
    write_register(CFG_REGION_COUNT, REGION_BITS'((1 << COUNT_BITS) - 1));
    send_pixel(make_pixel(115, 215, 200, 3, 0));
    write_register(CFG_REGION_COUNT, REGION_BITS'(0));
    send_pixel(make_pixel(105, 205, 200, 3, 0));
    for (int i = int'(CFG_REGION_THREE) + 1; i < (1 << CFG_IDX_BITS); i++) begin
      write_register(CFG_IDX_BITS'(i), '1);
    end
    write_register(CFG_REGION_COUNT, REGION_BITS'(REGIONS));
    send_pixel(make_pixel(105, 205, 0, 128, 127));
    send_pixel(make_pixel(300, 350, 0, 128, 127));
  endtask

  // fresh random regions per setting, one pause to empty the pipe halfway
  task automatic test_random_traffic(input int settings, input int items);
    for (int s = 0; s < settings; s++) begin
      for (int k = 0; k < REG_SLOTS; k++) begin
        write_register(CFG_IDX_BITS'(int'(CFG_REGION_ZERO) + k), random_rect());
      end
      write_register(CFG_REGION_COUNT,
                     REGION_BITS'((s == 0) ? REGIONS : $urandom_range(7)));
      settings_used++;
      for (int i = 0; i < items; i++) begin
        if (i == items / 2) drain_pixels();
        send_pixel(random_pixel());
      end
    end
  endtask

  // output side stalls at random, set by receiver_idle_pct
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // compare each output transfer with the oldest pending pixel
  always @(posedge clk) begin : check_output
    pix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("output transfer with no pixel pending");
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.red_out !== want.red_out) begin
          $error("red_out: expected %0d, got %0d", want.red_out, out_data.red_out);
          errors++;
        end
        if (out_data.green_out !== want.green_out) begin
          $error("green_out: expected %0d, got %0d", want.green_out, out_data.green_out);
          errors++;
        end
        if (out_data.blue_out !== want.blue_out) begin
          $error("blue_out: expected %0d, got %0d", want.blue_out, out_data.blue_out);
          errors++;
        end
        if (out_data.inside_region !== want.inside_region) begin
          $error("inside_region: expected %0d, got %0d", want.inside_region,
                 out_data.inside_region);
          errors++;
        end
      end
    end
  end

  // watchdog on any transfer, pixel in, pixel out or register write
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d pixels pending", expected_pixels.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough_after_reset();
    test_chroma_extremes();
    test_rectangle_edges();
    test_region_count_and_index();

    // busy receiver with a mostly active sender, then the reverse, then full rate
    sender_idle_pct = 26;
    receiver_idle_pct = 69;
    test_random_traffic(4, 118);
    sender_idle_pct = 69;
    receiver_idle_pct = 26;
    test_random_traffic(4, 118);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_traffic(4, 118);

    drain_pixels();
    // let any stray output show up before the verdict
    repeat (20) @(posedge clk);

    $display("%0d pixels over %0d random region settings plus directed cases,",
             pixels_sent, settings_used);
    $display("%0d of them inside an enabled rectangle, %0d mismatches", inside_sent, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/rrc_pkg.sv
sv/rrc_cfg.sv
sv/rrc_front.sv
sv/rrc_div_stage.sv
sv/rrc_back.sv
sv/roi_rg_chromaticity.sv
bench/roi_rg_chromaticity_test.sv
